[rtl/swm_pkg.sv]
package swm_pkg;

  // Deque capacity, equal to the largest window
  localparam int WINDOW_MAX = 64;
  localparam int AW         = $clog2(WINDOW_MAX);
  // Counts, fill level, window length and positions; positions live mod 2^CW
  localparam int CW         = AW + 1;
  localparam int DATA_W     = 32;
  localparam int CFG_W      = 7;

  typedef logic        [AW-1:0]     addr_t;
  typedef logic        [CW-1:0]     cnt_t;
  typedef logic signed [DATA_W-1:0] data_t;

  // Read addresses issued to the deque store
  typedef struct packed {
    addr_t head_addr;
    addr_t tail_addr;
  } rd_req_t;

  // Registered read data from the deque store
  typedef struct packed {
    data_t head_value;
    data_t tail_value;
    cnt_t  head_pos;
  } rd_rsp_t;

  // Append of one entry
  typedef struct packed {
    logic  en;
    addr_t addr;
    data_t value;
    cnt_t  pos;
  } wr_req_t;

  // Ring index base + off, with off at most WINDOW_MAX
  function automatic addr_t ring_add(addr_t base, cnt_t off);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(off);
    if (sum >= (CW+1)'(WINDOW_MAX)) begin
      sum = sum - (CW+1)'(WINDOW_MAX);
    end
    return sum[AW-1:0];
  endfunction

endpackage

[rtl/sliding_window_maximum.sv]
// Flow: an accepted item steps through RETIRE, which retires expired head entries, and POP,
// which drops each tail entry not larger than it; it is then appended, every item once, and
// its window maximum is registered once the window is full. The append waits while a result
// is stalled; only IDLE takes items, so the next item waits for the last append.
// Reset: synchronous; deque empty, positions and fill cleared, window_size = 1.
module sliding_window_maximum (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [swm_pkg::CFG_W-1:0]    cfg_wdata,   // window_size
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [swm_pkg::DATA_W-1:0]   s_tdata,     // [31:0] sample
  input  logic                         s_tuser,     // [0] start_of_sequence
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [swm_pkg::DATA_W-1:0]   m_tdata      // [31:0] window_max
);
  import swm_pkg::*;

  typedef enum logic [1:0] {IDLE, RETIRE, POP} state_t;

  state_t            state;
  addr_t             head;
  cnt_t              count;
  cnt_t              sidx;
  cnt_t              fill;
  logic [CFG_W-1:0]  window_size;
  data_t             cur_value;
  cnt_t              cur_pos;

  addr_t             head_next;
  cnt_t              count_next;
  cnt_t              k;
  cnt_t              age;
  cnt_t              fill_inc;
  logic              accept;
  logic              retire;
  logic              pop;
  logic              done;
  logic              commit;
  logic              emit;
  data_t             result;
  rd_req_t           rd;
  wr_req_t           wr;
  rd_rsp_t           rsp;

  assign s_tready = (state == IDLE);
  assign accept   = s_tvalid && s_tready;

  // Clamp window length to 1..WINDOW_MAX
  always_comb begin
    if (window_size == '0) begin
      k = CW'(1);
    end else if (int'(window_size) > WINDOW_MAX) begin
      k = CW'(WINDOW_MAX);
    end else begin
      k = CW'(window_size);
    end
  end

  // Decide this cycle's deque step
  always_comb begin
    age      = cur_pos - rsp.head_pos;
    retire   = (state == RETIRE) && (count != '0) && (age >= k);
    pop      = (((state == RETIRE) && !retire) || (state == POP)) && (count != '0) &&
               ($signed(cur_value) >= $signed(rsp.tail_value));
    done     = (state != IDLE) && !retire && !pop;
    commit   = done && (!m_tvalid || m_tready);
    fill_inc = (fill == CW'(WINDOW_MAX)) ? fill : fill + CW'(1);
    emit     = (fill_inc >= k);
    result   = (count != '0) ? rsp.head_value : cur_value;
  end

  // Next head and count, which also steer the store reads
  always_comb begin
    head_next  = head;
    count_next = count;
    priority if (accept && s_tuser) begin
      head_next  = '0;
      count_next = '0;
    end else if (retire) begin
      head_next  = ring_add(head, CW'(1));
      count_next = count - CW'(1);
    end else if (pop) begin
      count_next = count - CW'(1);
    end else if (commit) begin
      count_next = count + CW'(1);
    end
  end

  // Read head and tail of the deque as it stands next cycle; append on commit
  always_comb begin
    rd.head_addr = head_next;
    rd.tail_addr = ring_add(head_next, count_next - CW'(1));
    wr.en        = commit;
    wr.addr      = ring_add(head, count);
    wr.value     = cur_value;
    wr.pos       = cur_pos;
  end

  swm_deque_store u_store (
    .clk (clk),
    .rd  (rd),
    .wr  (wr),
    .rsp (rsp)
  );

  // Sequencer, deque pointers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= IDLE;
      head        <= '0;
      count       <= '0;
      sidx        <= '0;
      fill        <= '0;
      window_size <= CFG_W'(1);
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        window_size <= cfg_wdata;
      end
      head  <= head_next;
      count <= count_next;
      unique case (state)
        IDLE: begin
          if (accept) begin
            state <= RETIRE;
          end
        end
        RETIRE: begin
          if (pop) begin
            state <= POP;
          end else if (commit) begin
            state <= IDLE;
          end
        end
        POP: begin
          if (commit) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
      // Take the item; a start flag begins a new sequence at position zero
      if (accept) begin
        cur_value <= s_tdata;
        cur_pos   <= s_tuser ? '0 : sidx;
        if (s_tuser) begin
          fill <= '0;
        end
      end
      // Advance position and fill, present the window maximum
      if (commit) begin
        sidx <= cur_pos + CW'(1);
        fill <= fill_inc;
      end
      if (commit && emit) begin
        m_tvalid <= 1'b1;
        m_tdata  <= result;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

[rtl/swm_deque_store.sv]
module swm_deque_store (
  input  logic             clk,
  input  swm_pkg::rd_req_t rd,
  input  swm_pkg::wr_req_t wr,
  output swm_pkg::rd_rsp_t rsp
);
  import swm_pkg::*;

  data_t values    [WINDOW_MAX];
  cnt_t  positions [WINDOW_MAX];

  // Append on write, registered reads at head and tail
  always_ff @(posedge clk) begin
    if (wr.en) begin
      values[wr.addr]    <= wr.value;
      positions[wr.addr] <= wr.pos;
    end
    rsp.head_value <= values[rd.head_addr];
    rsp.tail_value <= values[rd.tail_addr];
    rsp.head_pos   <= positions[rd.head_addr];
  end

endmodule

[rtl/swm_checker.sv]
module swm_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tvalid,
  input logic                       s_tready,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [swm_pkg::DATA_W-1:0] m_tdata
);
  import swm_pkg::*;

  // Reset leaves no result pending
  a_reset_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result pending after reset");

  // Reset leaves the block ready for an item
  a_reset_ready: assert property (@(posedge clk) rst |=> s_tready)
    else $error("not ready after reset");

  // One item at a time: busy the cycle after an accept
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("item accepted while previous item in work");

  // Stalled result holds its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

endmodule

bind sliding_window_maximum swm_checker u_chk (.*);

[bench/sliding_window_maximum_tb.sv]
`timescale 1ns / 1ps

module sliding_window_maximum_tb;
  import swm_pkg::*;

  localparam int RANDOM_ITEMS = 1300;
  localparam int SETTLE_CYCLES = 200;
  localparam int HOLD_AFTER = 400;
  localparam int HOLD_CYCLES = 400;
  localparam int EXP_DEPTH = 4096;

  typedef enum {PAT_RANDOM, PAT_NARROW, PAT_RISING, PAT_FALLING, PAT_EXTREME} pat_t;

  // One directed row: optional window write before the item, then the item
  typedef struct packed {
    bit               set_size;
    logic [CFG_W-1:0] size;
    logic             sos;
    logic [31:0]      smp;
    bit               known;
    logic [31:0]      known_max;
  } drow_t;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;
  logic             s_tvalid;
  logic             s_tready;
  logic [31:0]      s_tdata;
  logic             s_tuser;
  logic             m_tvalid;
  logic             m_tready;
  logic [31:0]      m_tdata;

  sliding_window_maximum u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: monotonic deque of (value, position)
  data_t            dq_val [WINDOW_MAX];
  int unsigned      dq_pos [WINDOW_MAX];
  int unsigned      dq_head;
  int unsigned      dq_len;
  int unsigned      next_pos;
  int unsigned      seen;
  logic [CFG_W-1:0] wsize;

  // Expected maxima in arrival order
  data_t exp_store [EXP_DEPTH];
  int    exp_wr = 0;
  int    exp_rd = 0;
  int    mismatch_count;
  int    items_accepted;
  bit    hold_rx;
  bit    gapless;

  task automatic flag_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic int pending_count();
    return exp_wr - exp_rd;
  endfunction

  task automatic queue_max(input data_t v);
    exp_store[exp_wr % EXP_DEPTH] = v;
    exp_wr++;
  endtask

  // Advance the deque by one sample; return 1 with the window maximum if due
  function automatic bit window_max_step(input data_t smp, input logic sos,
                                         output data_t wmax);
    int unsigned span;
    int unsigned pos;
    int unsigned age;
    int unsigned slot;
    span = (wsize == 0) ? 1 : (wsize > WINDOW_MAX) ? WINDOW_MAX : wsize;
    if (sos) begin
      dq_head = 0;
      dq_len = 0;
      next_pos = 0;
      seen = 0;
    end
    pos = next_pos;
    // retire expired head entries
    while (dq_len > 0) begin
      age = pos - dq_pos[dq_head];
      if (age < span) break;
      dq_head = (dq_head + 1) % WINDOW_MAX;
      dq_len--;
    end
    // drop tail entries not larger than the new sample
    while (dq_len > 0 && smp >= dq_val[(dq_head + dq_len - 1) % WINDOW_MAX])
      dq_len--;
    if (dq_len >= WINDOW_MAX) begin
      dq_head = (dq_head + 1) % WINDOW_MAX;
      dq_len--;
    end
    slot = (dq_head + dq_len) % WINDOW_MAX;
    dq_val[slot] = smp;
    dq_pos[slot] = pos;
    dq_len++;
    next_pos = pos + 1;
    if (seen < WINDOW_MAX) seen++;
    wmax = dq_val[dq_head];
    return seen >= span;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Offer one item and wait for it to be taken; call at a falling edge
  task automatic push_sample(input data_t smp, input logic sos, input bit known,
                             input data_t known_max);
    int    gap;
    data_t wmax;
    bit    due;
    gap = gapless ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    s_tuser  <= sos;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    due = window_max_step(smp, sos, wmax);
    if (known) queue_max(known_max);
    else if (due) queue_max(wmax);
    items_accepted++;
    @(negedge clk);
  endtask

  // Write the window length once the block has gone quiet
  task automatic set_window(input logic [CFG_W-1:0] size);
    s_tvalid <= 1'b0;
    while (pending_count() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= size;
    wsize = size;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic data_t gen_sample(input pat_t pat, input int idx, input data_t base);
    case (pat)
      PAT_NARROW:  return data_t'(int'($urandom_range(0, 6)) - 3);
      PAT_RISING:  return base + data_t'(idx);
      PAT_FALLING: return base - data_t'(idx);
      PAT_EXTREME: begin
        case ($urandom_range(0, 3))
          0:       return 32'sh7FFF_FFFF;
          1:       return 32'sh8000_0000;
          2:       return 32'sh0;
          default: return -32'sd1;
        endcase
      end
      default:     return data_t'($urandom);
    endcase
  endfunction

  // Check each result against the oldest expected maximum
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_count() == 0) begin
        flag_mismatch($sformatf("unexpected window_max %0d", $signed(m_tdata)));
      end else begin
        if (m_tdata !== exp_store[exp_rd % EXP_DEPTH])
          flag_mismatch($sformatf("window_max got %0d want %0d",
                                  $signed(m_tdata), exp_store[exp_rd % EXP_DEPTH]));
        exp_rd++;
      end
    end
  end

  // Receiver: random stalls, bursts of steady acceptance, and the long hold
  initial begin
    int stall_left;
    int run_left;
    stall_left = 0;
    run_left = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_rx) begin
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
        if (run_left > 0) begin
          run_left--;
        end else begin
          stall_left = pick_gap();
          run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                 : $urandom_range(0, 10);
        end
      end
    end
  end

  // Hold off the receiver long enough for the block to back up
  initial begin
    hold_rx = 1'b0;
    wait (items_accepted >= HOLD_AFTER);
    @(posedge clk);
    hold_rx = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  drow_t dir_rows [0:17] = '{
    // window 1 after reset, start flag on the third row only: each sample is its own maximum
    '{1'b0, 7'd0,   1'b0, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF},
    '{1'b0, 7'd0,   1'b0, 32'h8000_0000, 1'b1, 32'h8000_0000},
    '{1'b0, 7'd0,   1'b1, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{1'b0, 7'd0,   1'b0, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
    // window 3: equal samples, extremes, then shrink to 2 mid-sequence
    '{1'b1, 7'd3,   1'b1, 32'd5,         1'b0, 32'd0},
    '{1'b0, 7'd0,   1'b0, 32'd3,         1'b0, 32'd0},
    '{1'b0, 7'd0,   1'b0, 32'd4,         1'b0, 32'd0},
    '{1'b0, 7'd0,   1'b0, 32'd4,         1'b0, 32'd0},
    '{1'b0, 7'd0,   1'b0, 32'h8000_0000, 1'b0, 32'd0},
    '{1'b0, 7'd0,   1'b0, 32'h7FFF_FFFF, 1'b0, 32'd0},
    '{1'b1, 7'd2,   1'b0, 32'd7,         1'b0, 32'd0},
    '{1'b0, 7'd0,   1'b0, 32'd1,         1'b0, 32'd0},
    // window 64: sequences cut short give nothing
    '{1'b1, 7'd64,  1'b1, 32'd10,        1'b0, 32'd0},
    '{1'b0, 7'd0,   1'b0, 32'd20,        1'b0, 32'd0},
    '{1'b0, 7'd0,   1'b1, 32'd30,        1'b0, 32'd0},
    // window zero acts as one
    '{1'b1, 7'd0,   1'b0, 32'hFFFF_FFFB, 1'b1, 32'hFFFF_FFFB},
    // oversize windows act as 64
    '{1'b1, 7'd127, 1'b1, 32'd9,         1'b0, 32'd0},
    '{1'b1, 7'd65,  1'b0, 32'd8,         1'b0, 32'd0}
  };

  // Stimulus: reset, directed rows, then random sequences
  initial begin
    int    target;
    int    n_seq;
    int    span;
    int    len;
    int    r;
    bit    carry_on;
    pat_t  pat;
    data_t base;
    logic [CFG_W-1:0] size;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    mismatch_count = 0;
    items_accepted = 0;
    gapless = 1'b0;
    dq_head = 0;
    dq_len = 0;
    next_pos = 0;
    seen = 0;
    wsize = 7'd1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].set_size) set_window(dir_rows[i].size);
      push_sample(data_t'(dir_rows[i].smp), dir_rows[i].sos, dir_rows[i].known,
                  data_t'(dir_rows[i].known_max));
    end

    target = items_accepted + RANDOM_ITEMS;
    carry_on = 1'b0;
    while (items_accepted < target) begin
      // choose the window for this phase, small ones most often
      r = $urandom_range(0, 99);
      if (r < 50)      size = $urandom_range(1, 8);
      else if (r < 75) size = $urandom_range(9, 63);
      else if (r < 85) size = 7'd64;
      else if (r < 92) size = $urandom_range(65, 127);
      else if (r < 96) size = 7'd0;
      else             size = 7'd127;
      set_window(size);
      span = (size == 0) ? 1 : (size > WINDOW_MAX) ? WINDOW_MAX : size;

      n_seq = $urandom_range(1, 3);
      for (int s = 0; s < n_seq; s++) begin
        r = $urandom_range(0, 99);
        if (r < 70)      len = span + $urandom_range(0, 40);
        else if (r < 85) len = $urandom_range(1, span);
        else             len = $urandom_range(130, 200);
        pat = pat_t'($urandom_range(0, 4));
        base = data_t'($urandom);
        gapless = ($urandom_range(0, 4) == 0);
        for (int k = 0; k < len; k++) begin
          // keep the running sequence across a window change now and then
          push_sample(gen_sample(pat, k, base), (k == 0) && !(s == 0 && carry_on),
                      1'b0, '0);
          // a little noise inside well-formed runs
          if ($urandom_range(0, 49) == 0) pat = pat_t'($urandom_range(0, 4));
        end
      end
      carry_on = ($urandom_range(0, 3) == 0);
    end

    gapless = 1'b0;
    s_tvalid <= 1'b0;
    while (pending_count() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (pending_count() != 0)
      flag_mismatch($sformatf("%0d expected results never came", pending_count()));
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
